[hw/rtl/mf3e_pkg.sv]
// ----------------------------------------------------------------------------
// mf3e_pkg
// Shared types and constants for the edge-aware 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3e_pkg;

    // Work queue between the pixel front end and the filter back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register index of the frame size register
    localparam logic REG_FRAME_SIZE = 1'b0;

    // Reset value of the frame size register
    localparam logic [5:0] FRAME_SIZE_RESET = 6'd32;

    // Position of a pixel in the frame, as the back end needs it
    typedef struct packed {
        logic r_ge1;   // row >= 1
        logic r_ge2;   // row >= 2
        logic r_last;  // row == size-1
        logic c_ge1;
        logic c_ge2;
        logic c_last;
    } t_pos_flags;

endpackage

[hw/rtl/mf3e_queue.sv]
// ----------------------------------------------------------------------------
// mf3e_queue
// Small register FIFO carrying window requests from front end to back end.
// ----------------------------------------------------------------------------
module mf3e_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output logic [W-1:0]                 o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == CW'(DEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow a write");

endmodule

[hw/rtl/mf3e_front.sv]
// ----------------------------------------------------------------------------
// mf3e_front
// Pixel intake: position counters, two-row line memory, 3x3 window columns,
// and one window request per pixel that produces results.
// ----------------------------------------------------------------------------
module mf3e_front #(
    parameter int MAX_SIDE   = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pixel_valid,
    input  logic [7:0]                         i_pixel,
    output logic                               o_pixel_ready,
    input  logic                               i_cfg_we,
    input  logic [5:0]                         i_cfg_size,
    input  logic [mf3e_pkg::QCNT_W-1:0]        i_q_count,
    output logic                               o_push,
    output logic [2:0][2:0][PIXEL_BITS-1:0]    o_win,
    output logic [$clog2(MAX_SIDE)-1:0]        o_row,
    output logic [$clog2(MAX_SIDE)-1:0]        o_col,
    output mf3e_pkg::t_pos_flags               o_flags
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int PB = PIXEL_BITS;

    logic [5:0]     r_size;
    logic [CW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  w_k_m1;
    logic           w_accept;
    mf3e_pkg::t_pos_flags w_flags;

    // line memory: each column holds {row r-1, row r-2}
    logic [2*PB-1:0] r_line [MAX_SIDE];
    logic [2*PB-1:0] r_rd;

    logic                 r_f1_v;
    logic [PB-1:0]        r_f1_pix;
    logic [CW-1:0]        r_f1_row;
    logic [CW-1:0]        r_f1_col;
    mf3e_pkg::t_pos_flags r_f1_flags;

    logic [2:0][PB-1:0] r_wa;   // column c-1
    logic [2:0][PB-1:0] r_wb;   // column c-2
    logic [2:0][PB-1:0] w_cv;   // column c

    always_comb begin
        int ksz;
        ksz = int'(r_size);
        if (ksz < 2) begin
            ksz = 2;
        end
        if (ksz > MAX_SIDE) begin
            ksz = MAX_SIDE;
        end
        w_k_m1 = CW'(ksz - 1);
    end

    assign o_pixel_ready = (int'(i_q_count) + int'(r_f1_v)) < mf3e_pkg::QUEUE_DEPTH;
    assign w_accept      = i_pixel_valid && o_pixel_ready;

    always_comb begin
        w_flags.r_ge1  = (r_row != '0);
        w_flags.r_ge2  = (r_row > CW'(1)) && (r_row != CW'(1)) && (r_row != '0);
        w_flags.r_last = (r_row == w_k_m1);
        w_flags.c_ge1  = (r_col != '0);
        w_flags.c_ge2  = (r_col > CW'(1)) && (r_col != CW'(1)) && (r_col != '0);
        w_flags.c_last = (r_col == w_k_m1);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cfg_we) begin
            n_row = '0;
            n_col = '0;
        end else if (w_accept) begin
            if (r_col == w_k_m1) begin
                n_col = '0;
                n_row = (r_row == w_k_m1) ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= mf3e_pkg::FRAME_SIZE_RESET;
            r_row  <= '0;
            r_col  <= '0;
            r_f1_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_size;
            end
            r_row  <= n_row;
            r_col  <= n_col;
            r_f1_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_pix   <= PB'(i_pixel);
            r_f1_row   <= r_row;
            r_f1_col   <= r_col;
            r_f1_flags <= w_flags;
        end
    end

    // read the column at intake, write it back in the next cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_line[r_col];
        end
        if (r_f1_v) begin
            r_line[r_f1_col] <= {r_f1_pix, r_rd[2*PB-1:PB]};
        end
    end

    assign w_cv = {r_f1_pix, r_rd[2*PB-1:PB], r_rd[PB-1:0]};

    always_ff @(posedge i_clk) begin
        if (r_f1_v) begin
            r_wb <= r_wa;
            r_wa <= w_cv;
        end
    end

    assign o_push  = r_f1_v
                     && (r_f1_flags.r_ge1 || r_f1_flags.r_last)
                     && (r_f1_flags.c_ge1 || r_f1_flags.c_last);
    assign o_win   = {w_cv, r_wa, r_wb};
    assign o_row   = r_f1_row;
    assign o_col   = r_f1_col;
    assign o_flags = r_f1_flags;

endmodule

[hw/rtl/mf3e_back.sv]
// ----------------------------------------------------------------------------
// mf3e_back
// Expands each window request into its one to four results and filters
// them: pad the clipped window, pick ranks 4 and 5, median or middle mean.
// ----------------------------------------------------------------------------
module mf3e_back #(
    parameter int MAX_SIDE   = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [2:0][2:0][PIXEL_BITS-1:0]    i_win,
    input  logic [$clog2(MAX_SIDE)-1:0]        i_row,
    input  logic [$clog2(MAX_SIDE)-1:0]        i_col,
    input  mf3e_pkg::t_pos_flags               i_flags,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [4:0]                         o_out_row,
    output logic [4:0]                         o_out_col,
    output logic [7:0]                         o_filtered,
    output logic                               o_last_of_item,
    output logic                               o_end_of_frame
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int PB = PIXEL_BITS;

    logic w_en;
    logic r_sa, r_sb;
    logic w_is_r, w_is_c, w_a_last, w_b_last;
    logic w_rm0, w_cm0;
    logic [8:0][PB-1:0] w_pad;

    logic               r_s1_v;
    logic [8:0][PB-1:0] r_s1_pix;
    logic [CW-1:0]      r_s1_i, r_s1_j;
    logic               r_s1_last, r_s1_eof, r_s1_is9;

    logic [PB-1:0]      w_v4, w_v5;

    logic               r_s2_v;
    logic [PB-1:0]      r_s2_v4, r_s2_v5;
    logic [CW-1:0]      r_s2_i, r_s2_j;
    logic               r_s2_last, r_s2_eof, r_s2_is9;

    logic [PB:0]        w_sum;

    logic               r_o_v;
    logic [4:0]         r_o_row, r_o_col;
    logic [7:0]         r_o_filt;
    logic               r_o_last, r_o_eof;

    // whole pipe holds while the output register is full and not taken
    assign w_en = !r_o_v || i_out_ready;

    // current result within the request: row r-1 or r, column c-1 or c
    assign w_is_r   = i_flags.r_ge1 ? r_sa : 1'b1;
    assign w_is_c   = i_flags.c_ge1 ? r_sb : 1'b1;
    assign w_a_last = (i_flags.r_ge1 && i_flags.r_last) ? r_sa : 1'b1;
    assign w_b_last = (i_flags.c_ge1 && i_flags.c_last) ? r_sb : 1'b1;
    assign o_pop    = w_en && i_valid && w_a_last && w_b_last;

    assign w_rm0 = w_is_r ? 1'b0 : i_flags.r_ge2;
    assign w_cm0 = w_is_c ? 1'b0 : i_flags.c_ge2;

    // missing cells: three low pads and two high for a corner, two and one
    // for an edge, so ranks 4 and 5 always land on the middle pair
    always_comb begin
        for (int cs = 0; cs < 3; cs++) begin
            for (int rs = 0; rs < 3; rs++) begin
                if ((cs != 0 || w_cm0) && (rs != 0 || w_rm0)) begin
                    w_pad[cs*3+rs] = i_win[cs][rs];
                end else if (cs < 2 && rs < 2) begin
                    w_pad[cs*3+rs] = '0;
                end else begin
                    w_pad[cs*3+rs] = '1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa   <= 1'b0;
            r_sb   <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_o_v  <= r_s2_v;
            if (i_valid) begin
                if (!w_b_last) begin
                    r_sb <= 1'b1;
                end else begin
                    r_sb <= 1'b0;
                    r_sa <= !w_a_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pix  <= w_pad;
            r_s1_i    <= w_is_r ? i_row : i_row - CW'(1);
            r_s1_j    <= w_is_c ? i_col : i_col - CW'(1);
            r_s1_last <= w_a_last && w_b_last;
            r_s1_eof  <= w_is_r && w_is_c;
            r_s1_is9  <= w_rm0 && w_cm0;
        end
    end

    // rank select: ties broken by position
    always_comb begin
        logic [3:0] rank;
        w_v4 = '0;
        w_v5 = '0;
        for (int a = 0; a < 9; a++) begin
            rank = '0;
            for (int b = 0; b < 9; b++) begin
                if (b != a && (r_s1_pix[b] < r_s1_pix[a]
                               || (r_s1_pix[b] == r_s1_pix[a] && b < a))) begin
                    rank = rank + 4'd1;
                end
            end
            if (rank == 4'd4) begin
                w_v4 = r_s1_pix[a];
            end
            if (rank == 4'd5) begin
                w_v5 = r_s1_pix[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_v4   <= w_v4;
            r_s2_v5   <= w_v5;
            r_s2_i    <= r_s1_i;
            r_s2_j    <= r_s1_j;
            r_s2_last <= r_s1_last;
            r_s2_eof  <= r_s1_eof;
            r_s2_is9  <= r_s1_is9;
        end
    end

    assign w_sum = {1'b0, r_s2_v4} + {1'b0, r_s2_v5};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_row  <= 5'(r_s2_i);
            r_o_col  <= 5'(r_s2_j);
            r_o_filt <= r_s2_is9 ? 8'(r_s2_v4) : 8'(w_sum[PB:1]);
            r_o_last <= r_s2_last;
            r_o_eof  <= r_s2_eof;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_filtered     = r_o_filt;
    assign o_last_of_item = r_o_last;
    assign o_end_of_frame = r_o_eof;

    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_valid && w_a_last && w_b_last))
        else $error("request retired before its last result");

    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_eof) |-> r_o_last)
        else $error("end of frame on a result that is not last of its pixel");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !i_out_ready) |=> (r_o_v && $stable(r_o_filt) && $stable(r_o_row)))
        else $error("stalled result changed");

endmodule

[hw/rtl/median_filter_3x3_edge_aware.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_edge_aware
// Edge-aware 3x3 median filter over a square raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on i_pixel_valid / o_pixel_ready, one per request, in raster
//   order. Results leave on o_out_valid / i_out_ready in row-major order, but
//   the last two rows come interleaved column by column; each result carries
//   its row, column, last-of-pixel and end-of-frame marks. Interior positions
//   give the 3x3 median, edges and corners the floored mean of the middle pair
//   of the clipped window. Row 0 and column 0 give no results; the pixel in the
//   last column gives two, other last-row pixels two, the final one four. The
//   intake takes one pixel per cycle while the queue has room; the filter
//   pipeline issues one result per cycle while the output is taken, and the
//   last row doubles the result count.
//   A 4-entry request queue lets intake run ahead through those bursts.
//   Writing frame_size (APB, address 0) restarts the frame at (0,0); write it
//   only while idle. Reset sets frame_size to 32 and empties all pipes; line
//   memory contents are not cleared. When the receiver stalls, the output
//   holds and the filter pipe freezes; intake stalls once the queue fills.
// ----------------------------------------------------------------------------
module median_filter_3x3_edge_aware #(
    parameter int MAX_SIDE   = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pixel_valid,
    input  logic [7:0]  i_pixel,
    output logic        o_pixel_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_out_row,
    output logic [4:0]  o_out_col,
    output logic [7:0]  o_filtered,
    output logic        o_last_of_item,
    output logic        o_end_of_frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int PB = PIXEL_BITS;
    localparam int FW = $bits(mf3e_pkg::t_pos_flags);
    localparam int EW = 9 * PB + 2 * CW + FW;

    logic       w_cfg_we;
    logic [5:0] r_size_shadow;

    logic                          w_push;
    logic [2:0][2:0][PB-1:0]       w_f_win;
    logic [CW-1:0]                 w_f_row, w_f_col;
    mf3e_pkg::t_pos_flags          w_f_flags;
    logic [mf3e_pkg::QCNT_W-1:0]   w_q_count;
    logic                          w_q_valid, w_q_pop;
    logic [EW-1:0]                 w_q_data;
    logic [2:0][2:0][PB-1:0]       w_b_win;
    logic [CW-1:0]                 w_b_row, w_b_col;
    mf3e_pkg::t_pos_flags          w_b_flags;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready
                      && (paddr[2] == mf3e_pkg::REG_FRAME_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_shadow <= mf3e_pkg::FRAME_SIZE_RESET;
        end else if (w_cfg_we) begin
            r_size_shadow <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == mf3e_pkg::REG_FRAME_SIZE) ? {26'd0, r_size_shadow} : '0;

    mf3e_front #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .i_pixel       (i_pixel),
        .o_pixel_ready (o_pixel_ready),
        .i_cfg_we      (w_cfg_we),
        .i_cfg_size    (pwdata[5:0]),
        .i_q_count     (w_q_count),
        .o_push        (w_push),
        .o_win         (w_f_win),
        .o_row         (w_f_row),
        .o_col         (w_f_col),
        .o_flags       (w_f_flags)
    );

    mf3e_queue #(
        .W     (EW),
        .DEPTH (mf3e_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_win, w_f_row, w_f_col, w_f_flags}),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign {w_b_win, w_b_row, w_b_col, w_b_flags} = w_q_data;

    mf3e_back #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_win          (w_b_win),
        .i_row          (w_b_row),
        .i_col          (w_b_col),
        .i_flags        (w_b_flags),
        .o_pop          (w_q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_filtered     (o_filtered),
        .o_last_of_item (o_last_of_item),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
